@@ hdl/rgbpwm_pkg.sv @@
`timescale 1ns / 1ps

package rgbpwm_pkg;

   localparam int BITS_PER_LED = 24;
   localparam int SLOT_W       = 12;
   localparam int COUNT_W      = 16;
   localparam int GAP_W        = 8;
   localparam int CHAN_W       = 8;
   localparam int INDEX_W      = 2;

   localparam logic [COUNT_W-1:0] PERIOD_RESET    = 16'd119;
   localparam logic [COUNT_W-1:0] ZERO_HIGH_RESET = 16'd38;
   localparam logic [COUNT_W-1:0] ONE_HIGH_RESET  = 16'd80;
   localparam logic [GAP_W-1:0]   GAP_RESET       = 8'd50;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SEND  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_PERIOD    = 2'd0,
      CSR_ZERO_HIGH = 2'd1,
      CSR_ONE_HIGH  = 2'd2,
      CSR_GAP       = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type              operation;
      logic [INDEX_W-1:0]  chain_pos;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
   } rsp_type;

endpackage

@@ hdl/rgb_led_chain_pwm_serializer.sv @@
// Serialiser for a chain of addressable RGB LEDs driven over one PWM data line.
// Request channel (req_valid, req_ready, req_data): one transaction per operation,
// either set colour, clear all entries, start send or tick (one timer clock).
// Response channel (rsp_valid, rsp_ready, rsp_data): exactly one transaction per
// request, carrying the line level and busy flag after that operation.
// Configuration channel (csr_valid, csr_ready, csr_index, csr_data): writes the
// period, zero and one high times and the latch gap; it is always ready.
// Colours live in a synchronous single-port-write memory with a registered read.
// The memory is read every cycle at the LED of the next bit slot, so the word
// is ready when the following tick opens that slot.
// A request is registered in the processing stage, its response in the response
// register; one request is taken every cycle while the receiver takes each
// response without stalling.
// Reset loads the register defaults, stops any frame and marks every entry as
// unwritten; no clearing pass over the memory is needed.
// When the receiver stalls, the response register and the processing stage hold;
// req_ready drops while the stage holds a request, until the response is taken.
`timescale 1ns / 1ps

module rgb_led_chain_pwm_serializer #(
   parameter int LEDS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rgbpwm_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rgbpwm_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  rgbpwm_pkg::csr_index_type             csr_index,
   input  logic [rgbpwm_pkg::COUNT_W-1:0]        csr_data
);

   localparam int LED_W      = (LEDS > 1) ? $clog2(LEDS) : 1;
   localparam int DATA_SLOTS = LEDS * rgbpwm_pkg::BITS_PER_LED;
   localparam int BIT_W      = $clog2(rgbpwm_pkg::BITS_PER_LED);
   localparam int COLOR_W    = rgbpwm_pkg::BITS_PER_LED;
   localparam int SLOT_W     = rgbpwm_pkg::SLOT_W;
   localparam int COUNT_W    = rgbpwm_pkg::COUNT_W;

   logic [COUNT_W-1:0]           period_ff;
   logic [COUNT_W-1:0]           zero_high_ff;
   logic [COUNT_W-1:0]           one_high_ff;
   logic [rgbpwm_pkg::GAP_W-1:0] gap_ff;

   logic [COLOR_W-1:0] color_mem [LEDS];
   logic [LEDS-1:0]    written_ff;
   logic [COLOR_W-1:0] rd_color_ff;
   logic               rd_written_ff;

   logic               s1_valid_ff;
   rgbpwm_pkg::req_type s1_req_ff;
   logic               rsp_valid_ff;
   rgbpwm_pkg::rsp_type rsp_ff;
   rgbpwm_pkg::rsp_type rsp_in;

   logic               sending_ff,  sending_in;
   logic [COUNT_W-1:0] tick_ff,     tick_in;
   logic [SLOT_W-1:0]  slot_ff,     slot_in;
   logic [COUNT_W-1:0] active_ff,   active_in;
   logic [LED_W-1:0]   pos_led_ff,  pos_led_in;
   logic [BIT_W-1:0]   pos_bit_ff,  pos_bit_in;

   logic               s1_adv;
   logic               req_take;
   logic               set_ok;
   logic [LED_W-1:0]   wr_addr;
   logic [SLOT_W-1:0]  slot_next;
   logic [SLOT_W-1:0]  total_slots;
   logic               data_bit;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign set_ok  = (32'(req_data.chain_pos) < LEDS);
   assign wr_addr = LED_W'(req_data.chain_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rgbpwm_pkg::PERIOD_RESET;
         zero_high_ff <= rgbpwm_pkg::ZERO_HIGH_RESET;
         one_high_ff  <= rgbpwm_pkg::ONE_HIGH_RESET;
         gap_ff       <= rgbpwm_pkg::GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rgbpwm_pkg::CSR_PERIOD:    period_ff    <= csr_data;
            rgbpwm_pkg::CSR_ZERO_HIGH: zero_high_ff <= csr_data;
            rgbpwm_pkg::CSR_ONE_HIGH:  one_high_ff  <= csr_data;
            rgbpwm_pkg::CSR_GAP:       gap_ff       <= csr_data[rgbpwm_pkg::GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_data.operation == rgbpwm_pkg::OP_SET && set_ok) begin
         color_mem[wr_addr] <= {req_data.green, req_data.red, req_data.blue};
      end
      rd_color_ff <= color_mem[pos_led_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         rd_written_ff <= written_ff[pos_led_in];
         if (req_take && req_data.operation == rgbpwm_pkg::OP_CLEAR) begin
            written_ff <= '0;
         end else if (req_take && req_data.operation == rgbpwm_pkg::OP_SET && set_ok) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         tick_ff    <= '0;
         slot_ff    <= '0;
         active_ff  <= '0;
         pos_led_ff <= '0;
         pos_bit_ff <= '0;
      end else begin
         sending_ff <= sending_in;
         tick_ff    <= tick_in;
         slot_ff    <= slot_in;
         active_ff  <= active_in;
         pos_led_ff <= pos_led_in;
         pos_bit_ff <= pos_bit_in;
      end
   end

   assign slot_next   = slot_ff + SLOT_W'(1);
   assign total_slots = SLOT_W'(DATA_SLOTS) +
                        ((gap_ff == '0) ? SLOT_W'(1) : SLOT_W'(gap_ff));
   assign data_bit    = rd_color_ff[BIT_W'(COLOR_W - 1) - pos_bit_ff];

   always_comb begin
      sending_in = sending_ff;
      tick_in    = tick_ff;
      slot_in    = slot_ff;
      active_in  = active_ff;
      pos_led_in = pos_led_ff;
      pos_bit_in = pos_bit_ff;
      if (s1_adv) begin
         case (s1_req_ff.operation)
            rgbpwm_pkg::OP_SEND: begin
               if (!sending_ff) begin
                  sending_in = 1'b1;
                  tick_in    = '0;
                  slot_in    = '0;
                  active_in  = '0;
                  pos_led_in = '0;
                  pos_bit_in = '0;
               end
            end
            rgbpwm_pkg::OP_TICK: begin
               if (sending_ff) begin
                  if (tick_ff >= period_ff) begin
                     tick_in = '0;
                     if (slot_next >= total_slots) begin
                        sending_in = 1'b0;
                        slot_in    = '0;
                        active_in  = '0;
                        pos_led_in = '0;
                        pos_bit_in = '0;
                     end else begin
                        slot_in = slot_next;
                        if (32'(slot_ff) < DATA_SLOTS && rd_written_ff) begin
                           active_in = data_bit ? one_high_ff : zero_high_ff;
                        end else begin
                           active_in = '0;
                        end
                        if (pos_bit_ff == BIT_W'(COLOR_W - 1)) begin
                           pos_bit_in = '0;
                           if (pos_led_ff != LED_W'(LEDS - 1)) begin
                              pos_led_in = pos_led_ff + LED_W'(1);
                           end
                        end else begin
                           pos_bit_in = pos_bit_ff + BIT_W'(1);
                        end
                     end
                  end else begin
                     tick_in = tick_ff + COUNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
      rsp_in.busy_res   = sending_in;
      rsp_in.line_level = sending_in && (tick_in < active_in);
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (slot_ff == '0 && active_ff == '0 && pos_bit_ff == '0))
      else $error("idle state not cleared");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_bit_ff) < rgbpwm_pkg::BITS_PER_LED)
      else $error("bit position out of range");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while processing stage is stalled");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> ($stable(sending_ff) && $stable(slot_ff) && $stable(tick_ff)))
      else $error("frame state moved without a processed transaction");

endmodule
